[rtl/core/avcd_pkg.sv]
`timescale 1ns / 1ps

package avcd_pkg;

    localparam int FLASH_PERIOD_DEF = 10;
    localparam int GLYPH_DEPTH_DEF  = 4096;

    // span of the raw glyph address (code*16 + row, or a write index)
    localparam int VADDR_W = 13;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [3:0] BORDER_COLOUR = 4'd1;

    // mode_control bit positions
    localparam int MC_CHARSET = 1;
    localparam int MC_HIRES   = 2;
    localparam int MC_TEXT    = 3;
    localparam int MC_CONTROL = 4;
    localparam int MC_FS      = 5;

    localparam logic [4:0] PIX_CNT_4  = 5'd4;
    localparam logic [4:0] PIX_CNT_8  = 5'd8;
    localparam logic [4:0] PIX_CNT_16 = 5'd16;

    localparam logic [4:0] UNDERLINE_ROW = 5'd9;

    typedef enum logic [1:0] {
        OP_CELL     = 2'd0,
        OP_FRAME    = 2'd1,
        OP_GLYPH_WR = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE_CONTROL = 3'd0,
        CFG_PALETTE_0    = 3'd1,
        CFG_PALETTE_1    = 3'd2,
        CFG_PALETTE_2    = 3'd3,
        CFG_PALETTE_3    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic       display_enable;
        logic [4:0] row_addr;
        logic       cursor_on;
        logic [7:0] data_lo;
        logic [7:0] data_hi;
        logic       flash_phase;
    } cell_t;

endpackage

[rtl/core/attribute_video_cell_decoder.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata cell/write fields, s_tuser op
// m_       out  m_tvalid/m_tready  m_tdata pixels, pixel_count
// cfg_     in   cfg_wr_en          cfg_index, cfg_data
//
// One request per cycle sustained while s_tready is high. A cell result
// is read from the glyph memory into the decode stage, then decoded into
// the output register. Frame ticks and glyph writes finish at accept.
// Synchronous active-low reset clears flash state, palette and mode; the
// glyph memory is not cleared. A stalled output holds the decode stage;
// s_tready drops only when both stages are full and m_tready is low.

module attribute_video_cell_decoder
    import avcd_pkg::*;
#(
    parameter int FLASH_PERIOD = FLASH_PERIOD_DEF,
    parameter int GLYPH_DEPTH  = GLYPH_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] display_enable, [5:1] row_addr, [6] cursor_on, [14:7] data_lo,
    // [22:15] data_hi, [34:23] rom_index, [42:35] rom_data, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] op
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [63:0] pixels, [68:64] pixel_count, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int AW        = $clog2(GLYPH_DEPTH);
    localparam int VSPAN     = 1 << VADDR_W;
    localparam int MOD_STEPS = $clog2((VSPAN + GLYPH_DEPTH - 1) / GLYPH_DEPTH);

    function automatic logic [AW-1:0] glyph_mod(input logic [VADDR_W-1:0] v);
        logic [VADDR_W:0] t;
        t = {1'b0, v};
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (t >= (VADDR_W + 1)'(GLYPH_DEPTH << k)) begin
                t = t - (VADDR_W + 1)'(GLYPH_DEPTH << k);
            end
        end
        return t[AW-1:0];
    endfunction

    // input unpack
    op_t         in_op;
    logic        in_de;
    logic [4:0]  in_ra;
    logic        in_cur;
    logic [7:0]  in_lo;
    logic [7:0]  in_hi;
    logic [11:0] in_ridx;
    logic [7:0]  in_rdat;

    assign in_op   = op_t'(s_tuser[1:0]);
    assign in_de   = s_tdata[0];
    assign in_ra   = s_tdata[5:1];
    assign in_cur  = s_tdata[6];
    assign in_lo   = s_tdata[14:7];
    assign in_hi   = s_tdata[22:15];
    assign in_ridx = s_tdata[34:23];
    assign in_rdat = s_tdata[42:35];

    // config registers
    logic [7:0] mode_reg;
    logic [3:0] pal_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                pal_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE_CONTROL: mode_reg   <= cfg_data;
                CFG_PALETTE_0:    pal_reg[0] <= cfg_data[3:0];
                CFG_PALETTE_1:    pal_reg[1] <= cfg_data[3:0];
                CFG_PALETTE_2:    pal_reg[2] <= cfg_data[3:0];
                CFG_PALETTE_3:    pal_reg[3] <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // handshake and pipeline control
    logic  s1_valid_reg;
    logic  out_valid_reg;
    logic  s1_adv;
    logic  s_acc;
    logic  cell_acc;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign cell_acc = s_acc && (in_op == OP_CELL);

    // flash divider
    logic [3:0] flash_count_reg;
    logic [3:0] flash_count_next;
    logic       flash_phase_reg;
    logic       flash_phase_next;

    always_comb begin
        flash_count_next = flash_count_reg;
        flash_phase_next = flash_phase_reg;
        if (s_acc && in_op == OP_FRAME) begin
            flash_count_next = flash_count_reg + 4'd1;
            if (flash_count_next == 4'(FLASH_PERIOD)) begin
                flash_count_next = '0;
                flash_phase_next = !flash_phase_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flash_count_reg <= '0;
            flash_phase_reg <= 1'b0;
        end else begin
            flash_count_reg <= flash_count_next;
            flash_phase_reg <= flash_phase_next;
        end
    end

    // glyph memory: write and read share one address
    logic [7:0]         glyph_mem [GLYPH_DEPTH];
    logic [7:0]         glyph_reg;
    logic [VADDR_W-1:0] raw_addr;
    logic [AW-1:0]      mem_addr;

    always_comb begin
        if (in_op == OP_GLYPH_WR) begin
            raw_addr = VADDR_W'(in_ridx);
        end else begin
            raw_addr = {1'b0, in_lo, 4'b0000} + VADDR_W'(in_ra);
        end
    end

    assign mem_addr = glyph_mod(raw_addr);

    always_ff @(posedge aclk) begin
        if (s_acc && in_op == OP_GLYPH_WR) begin
            glyph_mem[mem_addr] <= in_rdat;
        end
        if (cell_acc) begin
            glyph_reg <= glyph_mem[mem_addr];
        end
    end

    // decode stage
    cell_t s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (cell_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_acc) begin
            s1_reg.display_enable <= in_de;
            s1_reg.row_addr       <= in_ra;
            s1_reg.cursor_on      <= in_cur;
            s1_reg.data_lo        <= in_lo;
            s1_reg.data_hi        <= in_hi;
            s1_reg.flash_phase    <= flash_phase_reg;
        end
    end

    logic        m_text;
    logic        m_direct;
    logic        m_two;
    logic [4:0]  cnt_dec;
    logic [63:0] pix_dec;
    logic        ul;
    logic        inv;
    logic [2:0]  fg;
    logic [2:0]  bg;
    logic [15:0] word;

    assign m_text   = mode_reg[MC_TEXT];
    assign m_direct = !m_text && !mode_reg[MC_CONTROL];
    assign m_two    = !m_text && !m_direct && mode_reg[MC_HIRES] && !mode_reg[MC_FS];
    assign word     = {s1_reg.data_hi, s1_reg.data_lo};

    always_comb begin
        ul  = s1_reg.data_hi[6] && (s1_reg.row_addr == UNDERLINE_ROW)
              && !mode_reg[MC_CHARSET];
        inv = (s1_reg.data_hi[7] && s1_reg.flash_phase) ^ ul ^ s1_reg.cursor_on;
        fg  = inv ? s1_reg.data_hi[2:0] : s1_reg.data_hi[5:3];
        bg  = inv ? s1_reg.data_hi[5:3] : s1_reg.data_hi[2:0];

        if (m_text) begin
            cnt_dec = PIX_CNT_8;
        end else if (m_direct) begin
            cnt_dec = PIX_CNT_4;
        end else if (m_two) begin
            cnt_dec = PIX_CNT_16;
        end else begin
            cnt_dec = PIX_CNT_8;
        end

        pix_dec = '0;
        if (!s1_reg.display_enable) begin
            for (int i = 0; i < 16; i++) begin
                if (5'(i) < cnt_dec) begin
                    pix_dec[4*i +: 4] = BORDER_COLOUR;
                end
            end
        end else if (m_text) begin
            for (int i = 0; i < 8; i++) begin
                pix_dec[4*i +: 4] = glyph_reg[i] ? {1'b0, fg} : {1'b0, bg};
            end
        end else if (m_direct) begin
            for (int i = 0; i < 4; i++) begin
                pix_dec[4*i +: 4] = {s1_reg.data_lo[i], s1_reg.data_lo[i+4],
                                     s1_reg.data_hi[i], s1_reg.data_hi[i+4]};
            end
        end else if (m_two) begin
            for (int i = 0; i < 16; i++) begin
                pix_dec[4*i +: 4] = pal_reg[{1'b0, word[i]}];
            end
        end else begin
            for (int i = 0; i < 8; i++) begin
                pix_dec[4*i +: 4] = pal_reg[{word[i+8], word[i]}];
            end
        end
    end

    // output register
    logic [63:0] pix_reg;
    logic [4:0]  cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            pix_reg <= pix_dec;
            cnt_reg <= cnt_dec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, cnt_reg, pix_reg};

    // checks
    a_flash_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flash_count_reg < 4'(FLASH_PERIOD))
        else $error("flash count out of range");

    a_flash_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && in_op == OP_FRAME && flash_count_reg == 4'(FLASH_PERIOD - 1)
        |=> flash_phase_reg != $past(flash_phase_reg))
        else $error("flash phase did not toggle at period end");

    a_cell_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_acc |=> s1_valid_reg)
        else $error("accepted cell missing from decode stage");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && out_valid_reg && !m_tready |=> s1_valid_reg && $stable(s1_reg))
        else $error("decode stage lost while output stalled");

    a_count_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (cnt_reg == PIX_CNT_4 || cnt_reg == PIX_CNT_8
                           || cnt_reg == PIX_CNT_16))
        else $error("illegal pixel count");

endmodule
